[design/aps_pkg.sv]
`timescale 1ns / 1ps

package aps_pkg;

   // Default coordinate width; the top level can override it.
   localparam int COORD_WIDTH_DEF = 16;

   // Output angle, signed Q3.13 radians.
   localparam int ANGLE_WIDTH = 16;

   // Ratio magnitude in Q1.15, up to and including 1.0.
   localparam int QUO_WIDTH = 16;

   // Polynomial term in Q.30 and the product with the ratio in Q.45.
   localparam int POLY_WIDTH  = 31;
   localparam int PROD_WIDTH  = 48;
   localparam int ROUND_SHIFT = 32;

   localparam logic [QUO_WIDTH-1:0]  Z_ONE       = 16'h8000;
   localparam logic [POLY_WIDTH-1:0] POLY_BASE   = 31'd843317248;   // round(pi/4 * 2^15) * 2^15
   localparam logic [POLY_WIDTH-1:0] POLY_SLOPE  = 31'd8946;        // round(0.273 * 2^15)
   localparam logic [PROD_WIDTH-1:0] ROUND_CONST = 48'h0000_8000_0000;

   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_PI      = 16'sd25736;
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_HALF_PI = 16'sd12868;

   // Angle offset that the quadrant of the point selects.
   typedef enum logic [2:0] {
      BASE_ZERO,
      BASE_PI,
      BASE_NEG_PI,
      BASE_HALF_PI,
      BASE_NEG_HALF_PI
   } base_type;

   // Quadrant information that travels with each item through the pipeline.
   typedef struct packed {
      base_type base;
      logic     flip;   // subtract the arctangent magnitude instead of adding it
   } tag_type;

   // Offset in Q3.13 for a quadrant code.
   function automatic logic signed [ANGLE_WIDTH-1:0] base_angle(input base_type base);
      logic signed [ANGLE_WIDTH-1:0] value;
      begin
         unique case (base)
            BASE_ZERO:        value = '0;
            BASE_PI:          value = ANGLE_PI;
            BASE_NEG_PI:      value = -ANGLE_PI;
            BASE_HALF_PI:     value = ANGLE_HALF_PI;
            BASE_NEG_HALF_PI: value = -ANGLE_HALF_PI;
            default:          value = '0;
         endcase
         return value;
      end
   endfunction

endpackage

[design/atan2_polynomial_approx.sv]
`timescale 1ns / 1ps

// Channel   Ports                                Direction  Handshake
// request   req_y_coord, req_x_coord             in         start high, busy low
// response  rsp_angle                            out        rsp_valid strobe, one cycle
//
// A new item is taken in every cycle; busy is always low.
// Each item's angle appears in the order taken; it passes the input registers, the divider,
// the polynomial stages and the output register. The divider resolves one quotient bit per stage.
// Synchronous reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module atan2_polynomial_approx #(
   parameter int COORD_WIDTH = aps_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_y_coord,
   input  logic signed [COORD_WIDTH-1:0]          req_x_coord,
   output logic                                   rsp_valid,
   output logic signed [aps_pkg::ANGLE_WIDTH-1:0] rsp_angle
);

   localparam int MW = COORD_WIDTH;
   localparam int QB = aps_pkg::QUO_WIDTH;
   localparam int AW = aps_pkg::ANGLE_WIDTH;

   logic             v1_ff;
   logic [MW-1:0]    my_ff;
   logic [MW-1:0]    mx_ff;
   logic             yneg_ff;
   logic             xneg_ff;

   logic             v2_ff;
   logic [MW-1:0]    num_ff;
   logic [MW-1:0]    den_ff;
   aps_pkg::tag_type tag2_ff;

   logic [MW-1:0]    my_in;
   logic [MW-1:0]    mx_in;
   logic [MW-1:0]    num_in;
   logic [MW-1:0]    den_in;
   aps_pkg::tag_type tag2_in;
   logic             swap;
   logic             origin;

   logic             div_valid;
   logic [QB-1:0]    div_quo;
   aps_pkg::tag_type div_tag;

   logic             poly_valid;
   logic [AW-1:0]    poly_atan;
   aps_pkg::tag_type poly_tag;

   logic             rsp_valid_ff;
   logic signed [AW-1:0] rsp_angle_ff;
   logic signed [AW-1:0] term;
   logic signed [AW-1:0] angle_in;

   assign busy = 1'b0;

   // Magnitudes; the most negative value maps to its unsigned magnitude.
   assign my_in = req_y_coord[MW-1] ? (~req_y_coord + MW'(1)) : req_y_coord;
   assign mx_in = req_x_coord[MW-1] ? (~req_x_coord + MW'(1)) : req_x_coord;

   // Ratio operands and quadrant code. The origin divides zero by one.
   always_comb begin
      swap    = ~(mx_ff > my_ff);
      origin  = (mx_ff == '0) && (my_ff == '0);
      num_in  = swap ? mx_ff : my_ff;
      den_in  = swap ? my_ff : mx_ff;
      tag2_in.flip = yneg_ff ^ xneg_ff ^ swap;
      priority if (origin) begin
         num_in       = '0;
         den_in       = MW'(1);
         tag2_in.base = aps_pkg::BASE_ZERO;
      end else if (swap) begin
         tag2_in.base = yneg_ff ? aps_pkg::BASE_NEG_HALF_PI : aps_pkg::BASE_HALF_PI;
      end else if (xneg_ff) begin
         tag2_in.base = yneg_ff ? aps_pkg::BASE_NEG_PI : aps_pkg::BASE_PI;
      end else begin
         tag2_in.base = aps_pkg::BASE_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      my_ff   <= my_in;
      mx_ff   <= mx_in;
      yneg_ff <= req_y_coord[MW-1];
      xneg_ff <= req_x_coord[MW-1];
      num_ff  <= num_in;
      den_ff  <= den_in;
      tag2_ff <= tag2_in;
   end

   aps_div_pipe #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_tag    (tag2_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   aps_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_mag    (div_quo),
      .in_tag    (div_tag),
      .out_valid (poly_valid),
      .out_atan  (poly_atan),
      .out_tag   (poly_tag)
   );

   // Apply the arctangent to the quadrant offset.
   assign term     = poly_tag.flip ? -$signed(poly_atan) : $signed(poly_atan);
   assign angle_in = aps_pkg::base_angle(poly_tag.base) + term;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= poly_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;

endmodule

[design/aps_div_pipe.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider: quotient = floor(num * 2^15 / den), num <= den.
// One quotient bit is resolved in each stage, most significant bit first.
module aps_div_pipe #(
   parameter int COORD_WIDTH = aps_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [COORD_WIDTH-1:0]         in_num,
   input  logic [COORD_WIDTH-1:0]         in_den,
   input  aps_pkg::tag_type               in_tag,
   output logic                           out_valid,
   output logic [aps_pkg::QUO_WIDTH-1:0]  out_quo,
   output aps_pkg::tag_type               out_tag
);

   localparam int QB = aps_pkg::QUO_WIDTH;
   localparam int MW = COORD_WIDTH;

   logic [QB-1:0]    valid_ff;
   logic [MW-1:0]    rem_ff [QB];
   logic [MW-1:0]    den_ff [QB];
   logic [QB-1:0]    quo_ff [QB];
   aps_pkg::tag_type tag_ff [QB];

   logic [MW-1:0]    rem_in [QB];
   logic [MW-1:0]    den_in [QB];
   logic [QB-1:0]    quo_in [QB];
   aps_pkg::tag_type tag_in [QB];

   // Valid bits shift along with the items.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QB-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [MW:0]   shifted;
      logic [MW+1:0] diff;
      logic          qbit;

      // Trial subtraction of the divisor from the shifted partial remainder.
      if (k == 0) begin : g_first
         assign shifted   = {1'b0, in_num};
         assign den_in[k] = in_den;
         assign tag_in[k] = in_tag;
      end else begin : g_next
         assign shifted   = {rem_ff[k-1], 1'b0};
         assign den_in[k] = den_ff[k-1];
         assign tag_in[k] = tag_ff[k-1];
      end

      assign diff      = {1'b0, shifted} - {2'b00, den_in[k]};
      assign qbit      = ~diff[MW+1];
      assign rem_in[k] = qbit ? diff[MW-1:0] : shifted[MW-1:0];

      if (k == 0) begin : g_q_first
         assign quo_in[k] = {{(QB-1){1'b0}}, qbit};
      end else begin : g_q_next
         assign quo_in[k] = {quo_ff[k-1][QB-2:0], qbit};
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         quo_ff[k] <= quo_in[k];
         tag_ff[k] <= tag_in[k];
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quo   = quo_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

endmodule

[design/aps_poly.sv]
`timescale 1ns / 1ps

// Arctangent magnitude |z| * (pi/4 + 0.273 * (1 - |z|)), rounded to Q3.13.
// Three stages: polynomial term, product, rounding.
module aps_poly (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [aps_pkg::QUO_WIDTH-1:0]    in_mag,
   input  aps_pkg::tag_type                 in_tag,
   output logic                             out_valid,
   output logic [aps_pkg::ANGLE_WIDTH-1:0]  out_atan,
   output aps_pkg::tag_type                 out_tag
);

   localparam int QB = aps_pkg::QUO_WIDTH;
   localparam int PW = aps_pkg::POLY_WIDTH;
   localparam int XW = aps_pkg::PROD_WIDTH;
   localparam int AW = aps_pkg::ANGLE_WIDTH;
   localparam int RS = aps_pkg::ROUND_SHIFT;

   logic [2:0]       valid_ff;
   logic [QB-1:0]    mag_a_ff;
   logic [PW-1:0]    poly_ff;
   logic [XW-1:0]    prod_ff;
   logic [AW-1:0]    atan_ff;
   aps_pkg::tag_type tag_a_ff;
   aps_pkg::tag_type tag_b_ff;
   aps_pkg::tag_type tag_c_ff;

   logic [QB-1:0]    comp;
   logic [PW-1:0]    poly_in;
   logic [XW-1:0]    prod_in;
   logic [XW-1:0]    rounded;
   logic [AW-1:0]    atan_in;

   // Polynomial term in Q.30.
   assign comp    = aps_pkg::Z_ONE - in_mag;
   assign poly_in = aps_pkg::POLY_BASE + PW'(comp) * aps_pkg::POLY_SLOPE;

   // Product with the ratio magnitude in Q.45.
   assign prod_in = XW'(mag_a_ff) * XW'(poly_ff);

   // Round half up to Q3.13.
   assign rounded = prod_ff + aps_pkg::ROUND_CONST;
   assign atan_in = rounded[RS+AW-1:RS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= in_mag;
      poly_ff  <= poly_in;
      tag_a_ff <= in_tag;
      prod_ff  <= prod_in;
      tag_b_ff <= tag_a_ff;
      atan_ff  <= atan_in;
      tag_c_ff <= tag_b_ff;
   end

   assign out_valid = valid_ff[2];
   assign out_atan  = atan_ff;
   assign out_tag   = tag_c_ff;

endmodule

[bench/atan2_angle_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the arctangent block, predicts the angle of every
// accepted point and compares each returned angle with the oldest prediction.
module atan2_angle_checker #(
   parameter int COORD_WIDTH = aps_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_y_coord,
   input  logic signed [COORD_WIDTH-1:0]          req_x_coord,
   input  logic                                   rsp_valid,
   input  logic signed [aps_pkg::ANGLE_WIDTH-1:0] rsp_angle,
   output int                                     failure_count,
   output int                                     pending_count
);

   // Fixed-point constants of the approximation.
   localparam logic [30:0]        QUARTER_PI_Q30 = 31'd843317248;
   localparam logic [30:0]        ATAN_SLOPE_Q15 = 31'd8946;
   localparam logic [30:0]        Z_UNIT         = 31'd32768;
   localparam logic [47:0]        ROUND_HALF     = 48'h0000_8000_0000;
   localparam logic signed [17:0] PI_Q13         = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13    = 18'sd12868;

   typedef struct {
      logic signed [COORD_WIDTH-1:0]          y_coord;
      logic signed [COORD_WIDTH-1:0]          x_coord;
      logic signed [aps_pkg::ANGLE_WIDTH-1:0] angle;
   } angle_entry;

   angle_entry expected_angles[$];

   initial begin
      failure_count = 0;
      pending_count = 0;
   end

   // Four-quadrant angle of a point, Q3.13, as the block should compute it.
   function automatic logic signed [aps_pkg::ANGLE_WIDTH-1:0] predict_angle(
      input logic signed [COORD_WIDTH-1:0] y_coord,
      input logic signed [COORD_WIDTH-1:0] x_coord
   );
      logic [COORD_WIDTH-1:0]  mag_y;
      logic [COORD_WIDTH-1:0]  mag_x;
      logic [COORD_WIDTH-1:0]  num_mag;
      logic [COORD_WIDTH-1:0]  den_mag;
      logic [COORD_WIDTH+14:0] quotient;
      logic [15:0]             z_mag;
      logic [30:0]             poly;
      logic [47:0]             product;
      logic [15:0]             atan_mag;
      logic                    z_neg;
      logic signed [17:0]      atan_signed;
      logic signed [17:0]      angle;
      begin
         // Magnitudes fit in the coordinate width even for the most negative value.
         mag_y = y_coord[COORD_WIDTH-1] ? -y_coord : y_coord;
         mag_x = x_coord[COORD_WIDTH-1] ? -x_coord : x_coord;
         if (x_coord == 0) begin
            if (y_coord > 0)
               angle = HALF_PI_Q13;
            else if (y_coord < 0)
               angle = -HALF_PI_Q13;
            else
               angle = '0;
         end else begin
            // The smaller magnitude is divided by the larger one.
            if (mag_x > mag_y) begin
               num_mag = mag_y;
               den_mag = mag_x;
            end else begin
               num_mag = mag_x;
               den_mag = mag_y;
            end
            z_neg    = y_coord[COORD_WIDTH-1] ^ x_coord[COORD_WIDTH-1];
            quotient = {num_mag, 15'b0} / den_mag;
            z_mag    = (quotient > Z_UNIT) ? Z_UNIT[15:0] : quotient[15:0];

            // Polynomial in Q.30, product in Q.45, rounded half up to Q3.13.
            poly     = QUARTER_PI_Q30 + ATAN_SLOPE_Q15 * (Z_UNIT - z_mag);
            product  = z_mag * poly;
            product  = product + ROUND_HALF;
            atan_mag = product[47:32];
            atan_signed = z_neg ? -$signed({2'b00, atan_mag}) : $signed({2'b00, atan_mag});

            // Quadrant correction.
            if (mag_x > mag_y) begin
               if (!x_coord[COORD_WIDTH-1])
                  angle = atan_signed;
               else if (!y_coord[COORD_WIDTH-1])
                  angle = atan_signed + PI_Q13;
               else
                  angle = atan_signed - PI_Q13;
            end else begin
               if (!y_coord[COORD_WIDTH-1])
                  angle = HALF_PI_Q13 - atan_signed;
               else
                  angle = -HALF_PI_Q13 - atan_signed;
            end
         end
         return angle[aps_pkg::ANGLE_WIDTH-1:0];
      end
   endfunction

   // Compare returned angles first, then record the item accepted at this edge.
   always @(posedge clock) begin
      angle_entry oldest;
      angle_entry fresh;
      if (reset) begin
         expected_angles.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               $error("rsp_angle: unexpected result %0d with no item outstanding", rsp_angle);
               failure_count = failure_count + 1;
            end else begin
               oldest = expected_angles.pop_front();
               if (rsp_angle !== oldest.angle) begin
                  $error("rsp_angle mismatch for y=%0d x=%0d: expected %0d, actual %0d",
                         oldest.y_coord, oldest.x_coord, oldest.angle, rsp_angle);
                  failure_count = failure_count + 1;
               end
            end
         end
         if (start && !busy) begin
            fresh.y_coord = req_y_coord;
            fresh.x_coord = req_x_coord;
            fresh.angle   = predict_angle(req_y_coord, req_x_coord);
            expected_angles.push_back(fresh);
         end
      end
      pending_count = expected_angles.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Drives coordinate pairs into the arctangent block with random gaps and
// reports the verdict; the angles are checked in the angle checker.
module tb;

   localparam int COORD_W      = aps_pkg::COORD_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 1025;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TIME  = 40;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -(2 ** (COORD_W - 1));

   logic                                   clock;
   logic                                   reset;
   logic                                   start;
   logic                                   busy;
   logic signed [COORD_W-1:0]              req_y_coord;
   logic signed [COORD_W-1:0]              req_x_coord;
   logic                                   rsp_valid;
   logic signed [aps_pkg::ANGLE_WIDTH-1:0] rsp_angle;

   int failure_count;
   int pending_count;
   int stall_cycles = 0;
   bit steady_stream;

   logic signed [COORD_W-1:0] corner_values [0:5];

   atan2_polynomial_approx #(.COORD_WIDTH(COORD_W)) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_y_coord (req_y_coord),
      .req_x_coord (req_x_coord),
      .rsp_valid   (rsp_valid),
      .rsp_angle   (rsp_angle)
   );

   atan2_angle_checker #(.COORD_WIDTH(COORD_W)) angle_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_y_coord   (req_y_coord),
      .req_x_coord   (req_x_coord),
      .rsp_valid     (rsp_valid),
      .rsp_angle     (rsp_angle),
      .failure_count (failure_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Present one point, hold it until taken, then idle for a random gap.
   task automatic send_point(input logic signed [COORD_W-1:0] y_coord,
                             input logic signed [COORD_W-1:0] x_coord);
      int gap;
      int pick;
      begin
         @(negedge clock);
         start       <= 1'b1;
         req_y_coord <= y_coord;
         req_x_coord <= x_coord;
         do @(posedge clock); while (busy);
         if (steady_stream) begin
            gap = 0;
         end else begin
            pick = $urandom_range(99);
            if (pick < 65)
               gap = 0;
            else if (pick < 90)
               gap = $urandom_range(3, 1);
            else if (pick < 98)
               gap = $urandom_range(12, 4);
            else
               gap = $urandom_range(60, 20);
         end
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Stop sending and wait until every outstanding angle has come back.
   task automatic drain_results();
      begin
         @(negedge clock);
         start <= 1'b0;
         while (pending_count != 0) @(negedge clock);
      end
   endtask

   initial begin
      logic signed [COORD_W-1:0] rand_y;
      logic signed [COORD_W-1:0] rand_x;
      int mode;
      reset         = 1'b1;
      start         = 1'b0;
      req_y_coord   = '0;
      req_x_coord   = '0;
      steady_stream = 1'b0;
      corner_values[0] = COORD_MIN;
      corner_values[1] = COORD_MIN + 1;
      corner_values[2] = -1;
      corner_values[3] = 0;
      corner_values[4] = 1;
      corner_values[5] = COORD_MAX;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points: origin, axes, equal magnitudes, extremes, near the cut at pi.
      send_point(0, 0);
      send_point(100, 0);
      send_point(-100, 0);
      send_point(0, -5);
      send_point(0, 5);
      send_point(7, 7);
      send_point(7, -7);
      send_point(-7, 7);
      send_point(-7, -7);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX);
      send_point(COORD_MAX, COORD_MAX);
      send_point(0, COORD_MIN);
      send_point(COORD_MIN, 0);
      send_point(COORD_MAX, 0);
      send_point(1, COORD_MAX);
      send_point(-1, COORD_MIN);
      send_point(1, COORD_MIN);
      send_point(-1, COORD_MIN + 1);
      send_point(COORD_MAX, 1);
      send_point(COORD_MAX, -1);
      send_point(COORD_MIN, 1);
      send_point(-16'sd1, -16'sd1);
      drain_results();

      // Random points with a mix of shapes that stress each branch.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            steady_stream = ($urandom_range(3) == 0);
         if (n == 400 || n == 800)
            drain_results();
         mode = $urandom_range(99);
         if (mode < 50) begin
            rand_y = COORD_W'($urandom);
            rand_x = COORD_W'($urandom);
         end else if (mode < 65) begin
            rand_y = COORD_W'($urandom_range(8) - 4);
            rand_x = COORD_W'($urandom_range(8) - 4);
         end else if (mode < 80) begin
            // Equal magnitudes with random signs.
            rand_y = COORD_W'($urandom);
            rand_x = $urandom_range(1) ? rand_y : -rand_y;
            if ($urandom_range(1))
               rand_y = -rand_y;
         end else if (mode < 90) begin
            rand_y = COORD_W'($urandom);
            rand_x = COORD_W'($urandom);
            if ($urandom_range(1))
               rand_y = '0;
            else
               rand_x = '0;
         end else begin
            rand_y = corner_values[3'($urandom_range(5))];
            rand_x = corner_values[3'($urandom_range(5))];
         end
         send_point(rand_y, rand_x);
      end

      drain_results();
      repeat (SETTLE_TIME) @(posedge clock);
      if (pending_count != 0)
         $error("rsp_angle: %0d expected results never arrived", pending_count);
      if (failure_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
